FILE: src/asd_pkg.sv
// Shared types and constants for the accelerometer step detector.
// Used by asd_ctrl, asd_datapath and the top level; depends on nothing.

package asd_pkg;

    // Fixed field widths
    localparam int THR_W       = 14;
    localparam int MIN_W       = 16;
    localparam int SINCE_W     = 16;
    localparam int COUNT_W     = 32;
    localparam int OUT_W       = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // Magnitude value of 1.0 g in Q4.12 and the bits it needs
    localparam int ONE_G   = 4096;
    localparam int ONE_G_W = 13;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET    = THR_W'(1024);
    localparam logic [MIN_W-1:0]   MIN_INTERVAL_RESET = MIN_W'(10);
    localparam logic [SINCE_W-1:0] SINCE_MAX          = {SINCE_W{1'b1}};

    // Item operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD    = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_INTERVAL = CFG_INDEX_W'(1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       load;       // capture the input item
        logic       sq_step;    // square / accumulate step
        logic [1:0] sq_sel;     // axis 0..2, 3 = final accumulate
        logic       root_step;  // one bit of the square root
        logic       update;     // ring, running sum, sample counter
        logic       div_init;   // register the reciprocal product of the sum
        logic       div_last;   // store average from the product
        logic       finish;     // detection and result register load
    } asd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic op_clear;
    } asd_status_t;

endpackage

FILE: src/asd_ctrl.sv
// Sequencer for the step detector: steps the datapath through square,
// root, ring update, optional division and result load. Depends on asd_pkg.

module asd_ctrl #(
    parameter int WINDOW    = 16,
    parameter int AXIS_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  asd_pkg::asd_status_t status,
    output asd_pkg::asd_cmd_t    cmd
);

    localparam int HIST_W = (AXIS_BITS > asd_pkg::ONE_G_W) ? AXIS_BITS : asd_pkg::ONE_G_W;
    localparam int CNT_W  = $clog2(HIST_W + 1);
    localparam bit W_POW2 = ((WINDOW & (WINDOW - 1)) == 0);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_UPDATE,
        S_DIV_INIT,
        S_DIV,
        S_FINISH
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               out_valid_reg;
    logic               out_free;
    logic               root_last;

    assign out_free  = !out_valid_reg || out_ready;
    assign root_last = (cnt_reg == CNT_W'(AXIS_BITS - 1));
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && in_valid;
        cmd.sq_step   = (state_reg == S_SQUARE) && !status.op_clear;
        cmd.sq_sel    = cnt_reg[1:0];
        cmd.root_step = (state_reg == S_ROOT);
        cmd.update    = (state_reg == S_UPDATE);
        cmd.div_init  = (state_reg == S_DIV_INIT);
        cmd.div_last  = (state_reg == S_DIV);
        cmd.finish    = (state_reg == S_FINISH) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_valid)
                        state_reg <= S_SQUARE;
                end
                S_SQUARE:
                begin
                    // clear item skips straight to the result
                    if (status.op_clear)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else if (cnt_reg[1:0] == 2'd3)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_ROOT:
                begin
                    if (root_last)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_UPDATE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_UPDATE:
                begin
                    state_reg <= W_POW2 ? S_FINISH : S_DIV_INIT;
                end
                S_DIV_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    // hold until the result register is free
                    if (out_free)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: src/asd_datapath.sv
// Datapath of the step detector: squares, bit-serial square root, magnitude
// ring, average, detection state and result registers. Depends on asd_pkg.

module asd_datapath #(
    parameter int WINDOW    = 16,
    parameter int AXIS_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  asd_pkg::asd_cmd_t                    cmd,
    output asd_pkg::asd_status_t                 status,
    input  logic                                 cfg_write,
    input  logic [asd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 operation,
    input  logic signed [AXIS_BITS-1:0]          accel_x,
    input  logic signed [AXIS_BITS-1:0]          accel_y,
    input  logic signed [AXIS_BITS-1:0]          accel_z,
    output logic [asd_pkg::COUNT_W-1:0]          step_total,
    output logic                                 step_now,
    output logic [asd_pkg::OUT_W-1:0]            magnitude,
    output logic [asd_pkg::OUT_W-1:0]            average
);

    localparam int HIST_W = (AXIS_BITS > asd_pkg::ONE_G_W) ? AXIS_BITS : asd_pkg::ONE_G_W;
    localparam int LOG_W  = $clog2(WINDOW);
    localparam int POS_W  = LOG_W;
    localparam int SUM_W  = HIST_W + LOG_W;
    localparam int SQ_W   = 2 * AXIS_BITS;
    localparam int REM_W  = AXIS_BITS + 1;
    localparam int DIFF_W = HIST_W + 2;
    localparam bit W_POW2 = ((WINDOW & (WINDOW - 1)) == 0);

    // sum / WINDOW as (sum * RCP) >> RCP_SHIFT, exact for every SUM_W-bit sum
    localparam int RCP_SHIFT = SUM_W + LOG_W;
    localparam int PROD_W    = 2 * SUM_W + 1;
    localparam logic [SUM_W:0] RCP = (SUM_W + 1)'(((64'd1 << RCP_SHIFT)
                                     + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    localparam logic [SUM_W-1:0]  SUM_RESET = SUM_W'(asd_pkg::ONE_G * WINDOW);
    localparam logic [HIST_W-1:0] HIST_ONE  = HIST_W'(asd_pkg::ONE_G);

    // captured item
    logic                          op_reg;
    logic signed [AXIS_BITS-1:0]   ax_reg;
    logic signed [AXIS_BITS-1:0]   ay_reg;
    logic signed [AXIS_BITS-1:0]   az_reg;

    // squares and root
    logic signed [AXIS_BITS-1:0]   ax_sel;
    logic signed [SQ_W-1:0]        prod;
    logic [SQ_W-1:0]               prod_reg;
    logic [SQ_W-1:0]               acc_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [AXIS_BITS-1:0]          root_reg;
    logic [REM_W+1:0]              root_r2;
    logic [REM_W+1:0]              root_trial;
    logic                          root_ge;

    // ring of magnitudes
    logic [HIST_W-1:0]             mem [WINDOW];
    logic [WINDOW-1:0]             valid_reg;
    logic [HIST_W-1:0]             old_reg;
    logic                          old_valid_reg;
    logic [HIST_W-1:0]             old_val;
    logic [POS_W-1:0]              pos_reg;
    logic [SUM_W-1:0]              sum_reg;
    logic [SUM_W-1:0]              sum_next;
    logic [HIST_W-1:0]             mag;
    logic [HIST_W-1:0]             avg_reg;

    // average by reciprocal multiplication
    logic [PROD_W-1:0]             div_prod;
    logic [PROD_W-1:0]             div_prod_reg;

    // detection
    logic [asd_pkg::THR_W-1:0]     thr_reg;
    logic [asd_pkg::MIN_W-1:0]     min_reg;
    logic [asd_pkg::SINCE_W-1:0]   since_reg;
    logic                          armed_reg;
    logic [asd_pkg::COUNT_W-1:0]   count_reg;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [DIFF_W-1:0]      thr_ext;
    logic                          hit;

    // result registers
    logic [asd_pkg::COUNT_W-1:0]   step_total_reg;
    logic                          step_now_reg;
    logic [asd_pkg::OUT_W-1:0]     magnitude_reg;
    logic [asd_pkg::OUT_W-1:0]     average_reg;

    assign status.op_clear = op_reg;

    always_comb
    begin
        unique case (cmd.sq_sel)
            2'd0:    ax_sel = ax_reg;
            2'd1:    ax_sel = ay_reg;
            default: ax_sel = az_reg;
        endcase
    end

    assign prod = ax_sel * ax_sel;

    // one root bit: bring down two radicand bits, try root*4+1
    assign root_r2    = {rem_reg, acc_reg[SQ_W-1 -: 2]};
    assign root_trial = (REM_W + 2)'({root_reg, 2'b01});
    assign root_ge    = (root_r2 >= root_trial);

    assign mag      = HIST_W'(root_reg);
    assign old_val  = old_valid_reg ? old_reg : HIST_ONE;
    assign sum_next = sum_reg - SUM_W'(old_val) + SUM_W'(mag);

    assign div_prod = PROD_W'(sum_reg) * PROD_W'(RCP);

    assign diff    = $signed(DIFF_W'(mag)) - $signed(DIFF_W'(avg_reg));
    assign thr_ext = $signed(DIFF_W'(thr_reg));
    assign hit     = armed_reg && (diff < 0) && !(diff > thr_ext)
                     && (since_reg >= min_reg);

    // ring storage and its registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.update)
            mem[pos_reg] <= mag;
        old_reg <= mem[pos_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
        end
        if (cmd.sq_step)
        begin
            if (cmd.sq_sel != 2'd3)
                prod_reg <= SQ_W'(prod);
            if (cmd.sq_sel == 2'd0)
                acc_reg <= '0;
            else
                acc_reg <= acc_reg + prod_reg;
            if (cmd.sq_sel == 2'd3)
            begin
                rem_reg  <= '0;
                root_reg <= '0;
            end
        end
        else if (cmd.root_step)
        begin
            acc_reg  <= acc_reg << 2;
            rem_reg  <= root_ge ? REM_W'(root_r2 - root_trial) : REM_W'(root_r2);
            root_reg <= {root_reg[AXIS_BITS-2:0], root_ge};
        end
        if (cmd.div_init)
            div_prod_reg <= div_prod;
        if (cmd.finish)
        begin
            if (op_reg)
            begin
                step_total_reg <= '0;
                step_now_reg   <= 1'b0;
                magnitude_reg  <= '0;
            end
            else
            begin
                step_total_reg <= hit ? count_reg + asd_pkg::COUNT_W'(1) : count_reg;
                step_now_reg   <= hit;
                magnitude_reg  <= asd_pkg::OUT_W'(mag);
            end
            average_reg <= asd_pkg::OUT_W'(avg_reg);
        end
    end

    // control and detection state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg        <= 1'b0;
            valid_reg     <= '0;
            old_valid_reg <= 1'b0;
            pos_reg       <= '0;
            sum_reg       <= SUM_RESET;
            avg_reg       <= HIST_ONE;
            thr_reg       <= asd_pkg::THRESHOLD_RESET;
            min_reg       <= asd_pkg::MIN_INTERVAL_RESET;
            since_reg     <= asd_pkg::SINCE_MAX;
            armed_reg     <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            old_valid_reg <= valid_reg[pos_reg];
            if (cmd.load)
                op_reg <= (operation == asd_pkg::OP_CLEAR);
            if (cfg_write)
            begin
                if (cfg_index == asd_pkg::CFG_THRESHOLD)
                    thr_reg <= cfg_data[asd_pkg::THR_W-1:0];
                else if (cfg_index == asd_pkg::CFG_MIN_INTERVAL)
                    min_reg <= cfg_data[asd_pkg::MIN_W-1:0];
            end
            if (cmd.update)
            begin
                valid_reg[pos_reg] <= 1'b1;
                sum_reg            <= sum_next;
                if (pos_reg == POS_W'(WINDOW - 1))
                    pos_reg <= '0;
                else
                    pos_reg <= pos_reg + POS_W'(1);
                if (since_reg != asd_pkg::SINCE_MAX)
                    since_reg <= since_reg + asd_pkg::SINCE_W'(1);
                if (W_POW2)
                    avg_reg <= HIST_W'(sum_next >> LOG_W);
            end
            if (cmd.div_last)
                avg_reg <= HIST_W'(div_prod_reg >> RCP_SHIFT);
            if (cmd.finish)
            begin
                if (op_reg)
                begin
                    count_reg <= '0;
                end
                else
                begin
                    priority if (diff > thr_ext)
                    begin
                        armed_reg <= 1'b1;
                    end
                    else if (armed_reg && (diff < 0))
                    begin
                        armed_reg <= 1'b0;
                        if (hit)
                        begin
                            count_reg <= count_reg + asd_pkg::COUNT_W'(1);
                            since_reg <= '0;
                        end
                    end
                end
            end
        end
    end

    assign step_total = step_total_reg;
    assign step_now   = step_now_reg;
    assign magnitude  = magnitude_reg;
    assign average    = average_reg;

endmodule

FILE: src/accel_step_detector_unit.sv
// Top level of the accelerometer step detector: joins the sequencer and
// the datapath. Depends on asd_pkg, asd_ctrl and asd_datapath.
//
//  channel  signals                                         direction
//  in       in_valid/in_ready, operation, accel_x/y/z       into block
//  out      out_valid/out_ready, step_total, step_now,      out of block
//           magnitude, average
//  cfg      cfg_valid/cfg_ready, cfg_index, cfg_data        into block
//
// A sample item runs through the squares, the square root (one bit per cycle),
// the ring update and the result load; a WINDOW that is not a power of two
// adds the reciprocal multiply of the sum between update and result load.
// A clear item skips to the result load. One item is in work at a time; the next
// item is taken while the previous result waits in the output register.
// A stalled output holds the block in its last step. cfg_ready stays high.
// Reset restores the ring to 1.0 g entries at once through per-entry valid bits.

module accel_step_detector_unit #(
    parameter int WINDOW    = 16,
    parameter int AXIS_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 operation,
    input  logic signed [AXIS_BITS-1:0]          accel_x,
    input  logic signed [AXIS_BITS-1:0]          accel_y,
    input  logic signed [AXIS_BITS-1:0]          accel_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [asd_pkg::COUNT_W-1:0]          step_total,
    output logic                                 step_now,
    output logic [asd_pkg::OUT_W-1:0]            magnitude,
    output logic [asd_pkg::OUT_W-1:0]            average,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [asd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [asd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    asd_pkg::asd_cmd_t    cmd;
    asd_pkg::asd_status_t status;

    assign cfg_ready = 1'b1;

    asd_ctrl #(
        .WINDOW    (WINDOW),
        .AXIS_BITS (AXIS_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    asd_datapath #(
        .WINDOW    (WINDOW),
        .AXIS_BITS (AXIS_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .operation  (operation),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .step_total (step_total),
        .step_now   (step_now),
        .magnitude  (magnitude),
        .average    (average)
    );

endmodule

FILE: src/asd_checker.sv
// Port-level checks for the step detector, bound to the top level.
// Depends on asd_pkg and accel_step_detector_unit.

module asd_checker #(
    parameter int AXIS_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [asd_pkg::COUNT_W-1:0]   step_total,
    input logic                          step_now,
    input logic [asd_pkg::OUT_W-1:0]     magnitude,
    input logic [asd_pkg::OUT_W-1:0]     average
);

    localparam bit FULL_FIELDS = (AXIS_BITS <= asd_pkg::OUT_W);

    // one item in work at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in work");

    // a result only appears after an item was in work
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared with no item in work");

    // a counted step ends on a sample below the average
    a_step_below_avg: assert property (@(posedge clk) disable iff (!rst_n)
        (FULL_FIELDS && out_valid && step_now) |-> (magnitude < average))
        else $error("step counted on a sample not below the average");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(step_total) && $stable(step_now)
             && $stable(magnitude) && $stable(average)))
        else $error("stalled result changed");

endmodule

bind accel_step_detector_unit asd_checker #(
    .AXIS_BITS (AXIS_BITS)
) u_asd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .step_total (step_total),
    .step_now   (step_now),
    .magnitude  (magnitude),
    .average    (average)
);
